[src/assert_macros.svh]
// ----------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pst check failed");
`define PST_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pst check failed");
`else
`define PST_ASSERT(label, clk, rst, prop)
`define PST_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[src/pst_pkg.sv]
// ----------------------------------------------------------------------
// pst_pkg
// shared widths, codes and types of the phase-locked stimulus trigger
// ----------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   localparam int SAMPLE_BITS    = 13;
   localparam int AMP_BITS       = 12;
   localparam int TIME_BITS      = 32;
   localparam int TICK_BITS      = 24;
   localparam int TRIAL_BITS     = 16;
   localparam int UPPER_BITS     = 13;
   localparam int CMD_BITS       = 2;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int THR_BASE  = 4000;
   localparam int THR_SPAN  = 1500;
   localparam int SPAN_BITS = 11;
   localparam int PROD_BITS = SAMPLE_BITS + SPAN_BITS + 1;
   localparam int QUO_BITS  = SPAN_BITS;
   localparam int CMP_BITS  = SAMPLE_BITS + 4;

   localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_STOP  = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_LEVEL    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SINGLE   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_PERIODIC = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_SELECT,
      REG_STIM_KIND,
      REG_DRIVE_AMPLITUDE,
      REG_PULSE_TICKS,
      REG_PERIOD_TICKS,
      REG_ACTIVE_WINDOW,
      REG_INTERTRIAL,
      REG_TRIAL_COUNT
   } pst_reg_type;

   typedef struct packed {
      logic                  phase_select;
      logic [KIND_BITS-1:0]  stim_kind;
      logic [AMP_BITS-1:0]   drive_amplitude;
      logic [TICK_BITS-1:0]  pulse_ticks;
      logic [TICK_BITS-1:0]  period_ticks;
      logic [TIME_BITS-1:0]  active_window_ticks;
      logic [TIME_BITS-1:0]  intertrial_ticks;
      logic [TRIAL_BITS-1:0] trial_count;
   } pst_cfg_type;

   localparam pst_cfg_type CFG_RESET = '{
      phase_select:        1'b0,
      stim_kind:           KIND_LEVEL,
      drive_amplitude:     AMP_BITS'(4095),
      pulse_ticks:         TICK_BITS'(10000),
      period_ticks:        TICK_BITS'(50000),
      active_window_ticks: TIME_BITS'(1000000),
      intertrial_ticks:    TIME_BITS'(1000000),
      trial_count:         TRIAL_BITS'(1)
   };

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [UPPER_BITS-1:0] upper;
      logic                  hi;
      logic                  lo;
   } pst_thr_type;

   typedef struct packed {
      logic                  light_on;
      logic [AMP_BITS-1:0]   drive_level;
      logic                  busy_res;
      logic                  in_window;
      logic [TRIAL_BITS-1:0] trials_done;
      logic [UPPER_BITS-1:0] upper_threshold;
   } pst_rsp_type;

endpackage

`default_nettype wire

[src/phase_locked_stimulus_trigger.sv]
// ----------------------------------------------------------------------
// phase_locked_stimulus_trigger
// hysteresis phase detector gating a light source over a run of trials
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_ready   command, signal and knob samples
//   rsp      out        rsp_valid/rsp_ready   light, drive level, trial status
//   csr      in         csr_valid/csr_ready   register index and write data
//
// one word per clock while results are taken; a request passes the
// threshold stage register and then the result register
// reset is synchronous and clears the valid flags of both stages and all trial state
// a stalled result holds the pipe; the threshold stage still takes one word
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module phase_locked_stimulus_trigger (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pst_pkg::CMD_BITS-1:0]       req_command,
   input  logic [pst_pkg::SAMPLE_BITS-1:0]    req_signal_sample,
   input  logic [pst_pkg::SAMPLE_BITS-1:0]    req_knob_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_light_on,
   output logic [pst_pkg::AMP_BITS-1:0]       rsp_drive_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_in_window,
   output logic [pst_pkg::TRIAL_BITS-1:0]     rsp_trials_done,
   output logic [pst_pkg::UPPER_BITS-1:0]     rsp_upper_threshold,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pst_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import pst_pkg::*;

   pst_cfg_type cfg;
   pst_thr_type thr;
   pst_rsp_type rsp;
   logic        thr_valid;
   logic        thr_ready;

   pst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pst_thresh u_thresh (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_signal_sample (req_signal_sample),
      .req_knob_sample   (req_knob_sample),
      .thr_valid         (thr_valid),
      .thr_ready         (thr_ready),
      .thr               (thr)
   );

   pst_trial u_trial (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .thr_valid (thr_valid),
      .thr_ready (thr_ready),
      .thr       (thr),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_light_on        = rsp.light_on;
   assign rsp_drive_level     = rsp.drive_level;
   assign rsp_busy_res        = rsp.busy_res;
   assign rsp_in_window       = rsp.in_window;
   assign rsp_trials_done     = rsp.trials_done;
   assign rsp_upper_threshold = rsp.upper_threshold;

   `PST_ASSERT(a_light_in_window, clock, reset,
      (rsp_valid && rsp_light_on) |-> (rsp_busy_res && rsp_in_window))
   `PST_ASSERT(a_dark_drive_zero, clock, reset,
      (rsp_valid && !rsp_light_on) |-> (rsp_drive_level == '0))
   `PST_ASSERT(a_upper_range, clock, reset,
      rsp_valid |-> (rsp_upper_threshold >= UPPER_BITS'(THR_BASE)
                     && rsp_upper_threshold <= UPPER_BITS'(THR_BASE + THR_SPAN)))
   `PST_ASSERT(a_empty_takes, clock, reset, !rsp_valid |-> req_ready)
   `PST_ASSERT_NEXT(a_stage_fills, clock, reset, req_valid && req_ready, thr_valid)

endmodule

`default_nettype wire

[src/pst_csr.sv]
// ----------------------------------------------------------------------
// pst_csr
// configuration registers, written by index
// ----------------------------------------------------------------------
`default_nettype none

module pst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pst_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pst_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output pst_pkg::pst_cfg_type                 cfg
);
   import pst_pkg::*;

   pst_cfg_type cfg_ff;
   pst_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pst_reg_type'(csr_index))
            REG_PHASE_SELECT:    cfg_in.phase_select        = csr_data[0];
            REG_STIM_KIND:       cfg_in.stim_kind           = csr_data[KIND_BITS-1:0];
            REG_DRIVE_AMPLITUDE: cfg_in.drive_amplitude     = csr_data[AMP_BITS-1:0];
            REG_PULSE_TICKS:     cfg_in.pulse_ticks         = csr_data[TICK_BITS-1:0];
            REG_PERIOD_TICKS:    cfg_in.period_ticks        = csr_data[TICK_BITS-1:0];
            REG_ACTIVE_WINDOW:   cfg_in.active_window_ticks = csr_data[TIME_BITS-1:0];
            REG_INTERTRIAL:      cfg_in.intertrial_ticks    = csr_data[TIME_BITS-1:0];
            REG_TRIAL_COUNT:     cfg_in.trial_count         = csr_data[TRIAL_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/pst_thresh.sv]
// ----------------------------------------------------------------------
// pst_thresh
// input stage: knob to threshold and phase compares, registered
// ----------------------------------------------------------------------
`default_nettype none

module pst_thresh (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pst_pkg::CMD_BITS-1:0]       req_command,
   input  logic [pst_pkg::SAMPLE_BITS-1:0]    req_signal_sample,
   input  logic [pst_pkg::SAMPLE_BITS-1:0]    req_knob_sample,
   output logic                               thr_valid,
   input  logic                               thr_ready,
   output pst_pkg::pst_thr_type               thr
);
   import pst_pkg::*;

   logic [PROD_BITS-1:0]  prod;
   logic [PROD_BITS-1:0]  folded;
   logic [QUO_BITS-1:0]   quot;
   logic [UPPER_BITS-1:0] upper;
   logic [CMP_BITS-1:0]   ten_next;
   logic [CMP_BITS-1:0]   nine_upper;
   pst_thr_type           thr_in;
   pst_thr_type           thr_ff;
   logic                  thr_valid_ff;
   logic                  thr_valid_in;

   // divide by 2^n-1: fold the high part back in
   always_comb begin
      prod   = PROD_BITS'(req_knob_sample) * PROD_BITS'(THR_SPAN);
      folded = prod + (prod >> SAMPLE_BITS) + PROD_BITS'(1);
      quot   = QUO_BITS'(folded >> SAMPLE_BITS);
      upper  = UPPER_BITS'(THR_BASE) + UPPER_BITS'(quot);
      // sample below floor(upper*9/10) without a divider
      ten_next   = (CMP_BITS'(req_signal_sample) + CMP_BITS'(1)) * CMP_BITS'(10);
      nine_upper = CMP_BITS'(upper) * CMP_BITS'(9);
      thr_in.command = req_command;
      thr_in.upper   = upper;
      thr_in.hi      = CMP_BITS'(req_signal_sample) > CMP_BITS'(upper);
      thr_in.lo      = ten_next <= nine_upper;
   end

   assign req_ready    = !thr_valid_ff || thr_ready;
   assign thr_valid_in = (req_valid && req_ready) || (thr_valid_ff && !thr_ready);
   assign thr_valid    = thr_valid_ff;
   assign thr          = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_valid_ff <= 1'b0;
      end else begin
         thr_valid_ff <= thr_valid_in;
      end
      if (req_valid && req_ready) begin
         thr_ff <= thr_in;
      end
   end

endmodule

`default_nettype wire

[src/pst_trial.sv]
// ----------------------------------------------------------------------
// pst_trial
// trial sequencing, light gating and the result register
// ----------------------------------------------------------------------
`default_nettype none

module pst_trial (
   input  logic                    clock,
   input  logic                    reset,
   input  pst_pkg::pst_cfg_type    cfg,
   input  logic                    thr_valid,
   output logic                    thr_ready,
   input  pst_pkg::pst_thr_type    thr,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pst_pkg::pst_rsp_type    rsp
);
   import pst_pkg::*;

   logic                  running_ff, running_in;
   logic                  gap_ff, gap_in;
   logic [TRIAL_BITS-1:0] fin_ff, fin_in;
   logic [TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [TICK_BITS-1:0]  pulse_ff, pulse_in;
   logic [TICK_BITS-1:0]  since_ff, since_in;
   logic                  hyst_ff, hyst_in;
   logic                  level_ff, level_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pst_rsp_type           rsp_ff, rsp_in;

   logic                  take;
   logic                  light;
   logic                  complete;
   logic                  fire;
   logic                  enter;
   logic                  leave;
   logic                  hyst_tick;
   logic                  active;
   logic [TICK_BITS-1:0]  pulse_first;
   logic [TIME_BITS-1:0]  elapsed_inc;
   logic [TICK_BITS-1:0]  since_inc;

   assign thr_ready = !rsp_valid_ff || rsp_ready;
   assign take      = thr_valid && thr_ready;

   always_comb begin
      enter       = cfg.phase_select ? thr.lo : thr.hi;
      leave       = cfg.phase_select ? thr.hi : thr.lo;
      hyst_tick   = thr.hi ? 1'b1 : (thr.lo ? 1'b0 : hyst_ff);
      active      = hyst_tick == !cfg.phase_select;
      pulse_first = cfg.pulse_ticks - TICK_BITS'(cfg.pulse_ticks != '0);
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TIME_BITS'(1);
      since_inc   = (since_ff == '1) ? since_ff : since_ff + TICK_BITS'(1);
   end

   always_comb begin
      running_in = running_ff;
      gap_in     = gap_ff;
      fin_in     = fin_ff;
      elapsed_in = elapsed_ff;
      pulse_in   = pulse_ff;
      since_in   = since_ff;
      hyst_in    = hyst_ff;
      level_in   = level_ff;
      light      = 1'b0;
      complete   = 1'b0;
      fire       = 1'b0;
      case (thr.command)
         CMD_START: begin
            running_in = cfg.trial_count != '0;
            fin_in     = '0;
            gap_in     = 1'b0;
            elapsed_in = '0;
            pulse_in   = '0;
            since_in   = '0;
            hyst_in    = 1'b0;
            level_in   = 1'b0;
         end
         CMD_STOP: begin
            running_in = 1'b0;
            pulse_in   = '0;
            level_in   = 1'b0;
            gap_in     = 1'b0;
            elapsed_in = '0;
         end
         CMD_TICK: begin
            if (running_ff && !gap_ff) begin
               if (pulse_ff == '0 && elapsed_ff >= cfg.active_window_ticks) begin
                  // window over, this tick already counts as gap
                  gap_in     = 1'b1;
                  level_in   = 1'b0;
                  elapsed_in = (cfg.intertrial_ticks == '0) ? '0 : TIME_BITS'(1);
                  complete   = cfg.intertrial_ticks <= TIME_BITS'(1);
               end else begin
                  if (pulse_ff != '0) begin
                     pulse_in = pulse_ff - TICK_BITS'(1);
                     light    = 1'b1;
                  end else begin
                     hyst_in = hyst_tick;
                     case (cfg.stim_kind)
                        KIND_LEVEL: begin
                           level_in = leave ? 1'b0 : (enter ? 1'b1 : level_ff);
                           light    = level_in;
                        end
                        KIND_SINGLE: begin
                           if (enter && !level_ff) begin
                              pulse_in = pulse_first;
                              light    = cfg.pulse_ticks != '0;
                           end
                           level_in = leave ? 1'b0 : ((enter && !level_ff) ? 1'b1 : level_ff);
                        end
                        KIND_PERIODIC: begin
                           if (active && since_ff >= cfg.period_ticks) begin
                              fire     = 1'b1;
                              pulse_in = pulse_first;
                              light    = cfg.pulse_ticks != '0;
                           end
                        end
                        default: begin
                           light = 1'b0;
                        end
                     endcase
                  end
                  since_in   = fire ? TICK_BITS'(1) : since_inc;
                  elapsed_in = elapsed_inc;
               end
            end else if (running_ff) begin
               elapsed_in = elapsed_inc;
               complete   = elapsed_inc >= cfg.intertrial_ticks;
            end
         end
         default: begin
            light = running_ff && !gap_ff
                 && (pulse_ff != '0 || (cfg.stim_kind == KIND_LEVEL && level_ff));
         end
      endcase
      if (complete) begin
         fin_in     = fin_ff + TRIAL_BITS'(1);
         gap_in     = 1'b0;
         elapsed_in = '0;
         pulse_in   = '0;
         level_in   = 1'b0;
         if (fin_in >= cfg.trial_count) begin
            running_in = 1'b0;
         end else begin
            since_in = '0;
            hyst_in  = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in.light_on        = light;
      rsp_in.drive_level     = light ? cfg.drive_amplitude : '0;
      rsp_in.busy_res        = running_in;
      rsp_in.in_window       = running_in && !gap_in;
      rsp_in.trials_done     = fin_in;
      rsp_in.upper_threshold = thr.upper;
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         gap_ff       <= 1'b0;
         fin_ff       <= '0;
         elapsed_ff   <= '0;
         pulse_ff     <= '0;
         since_ff     <= '0;
         hyst_ff      <= 1'b0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            running_ff <= running_in;
            gap_ff     <= gap_in;
            fin_ff     <= fin_in;
            elapsed_ff <= elapsed_in;
            pulse_ff   <= pulse_in;
            since_ff   <= since_in;
            hyst_ff    <= hyst_in;
            level_ff   <= level_in;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[verif/phase_locked_stimulus_trigger_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// phase_locked_stimulus_trigger_checker
// watches the req, rsp and csr channels of the trigger, keeps its own
// copy of the registers and trial state, predicts one result word per
// accepted request word and compares each accepted result field by field
// ----------------------------------------------------------------------

module phase_locked_stimulus_trigger_checker
   import pst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [CMD_BITS-1:0]       req_command,
   input  logic [SAMPLE_BITS-1:0]    req_signal_sample,
   input  logic [SAMPLE_BITS-1:0]    req_knob_sample,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_light_on,
   input  logic [AMP_BITS-1:0]       rsp_drive_level,
   input  logic                      rsp_busy_res,
   input  logic                      rsp_in_window,
   input  logic [TRIAL_BITS-1:0]     rsp_trials_done,
   input  logic [UPPER_BITS-1:0]     rsp_upper_threshold,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        mismatches,
   output int                        words_due
);

   localparam int unsigned KNOB_FULL = (1 << SAMPLE_BITS) - 1;

   pst_cfg_type           cfg;
   logic                  running;
   logic                  gap_phase;
   logic                  hyst_high;
   logic                  level_on;
   logic [TRIAL_BITS-1:0] trials_fin;
   logic [TIME_BITS-1:0]  elapsed;
   logic [TICK_BITS-1:0]  pulse_left;
   logic [TICK_BITS-1:0]  since_start;

   pst_rsp_type due_responses[$];

   function automatic void begin_trial();
      gap_phase   = 1'b0;
      elapsed     = '0;
      pulse_left  = '0;
      since_start = '0;
      hyst_high   = 1'b0;
      level_on    = 1'b0;
   endfunction

   function automatic void finish_trial();
      trials_fin = trials_fin + 1'b1;
      if (trials_fin >= cfg.trial_count) begin
         running    = 1'b0;
         gap_phase  = 1'b0;
         elapsed    = '0;
         level_on   = 1'b0;
         pulse_left = '0;
      end else begin
         begin_trial();
      end
   endfunction

   function automatic logic fire_pulse();
      pulse_left = cfg.pulse_ticks;
      if (pulse_left != 0) begin
         pulse_left = pulse_left - 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic light_held();
      return running && !gap_phase &&
             (pulse_left != 0 || (cfg.stim_kind == KIND_LEVEL && level_on));
   endfunction

   function automatic pst_rsp_type trigger_response(logic [CMD_BITS-1:0] cmd,
                                                    logic [SAMPLE_BITS-1:0] sig,
                                                    logic [SAMPLE_BITS-1:0] knob);
      pst_rsp_type r;
      int unsigned knob_u;
      int unsigned sig_u;
      int unsigned upper;
      int unsigned lower;
      logic        light;
      logic        hi;
      logic        lo;
      logic        enter;
      logic        leave;
      knob_u = 32'(knob);
      sig_u  = 32'(sig);
      if (knob_u > KNOB_FULL) knob_u = KNOB_FULL;
      upper = THR_BASE + (knob_u * THR_SPAN) / KNOB_FULL;
      lower = (upper * 9) / 10;
      light = 1'b0;
      case (cmd)
         CMD_START: begin
            running    = 1'b1;
            trials_fin = '0;
            begin_trial();
            if (cfg.trial_count == 0) running = 1'b0;
            light = light_held();
         end
         CMD_STOP: begin
            running    = 1'b0;
            pulse_left = '0;
            level_on   = 1'b0;
            gap_phase  = 1'b0;
            elapsed    = '0;
         end
         CMD_TICK: begin
            if (running && !gap_phase) begin
               if (pulse_left == 0 && elapsed >= cfg.active_window_ticks) begin
                  // window over, this tick already belongs to the gap
                  gap_phase = 1'b1;
                  elapsed   = '0;
                  level_on  = 1'b0;
                  if (cfg.intertrial_ticks == 0) begin
                     finish_trial();
                  end else begin
                     elapsed = TIME_BITS'(1);
                     if (elapsed >= cfg.intertrial_ticks) finish_trial();
                  end
               end else begin
                  if (pulse_left != 0) begin
                     // samples ignored while a pulse runs
                     pulse_left = pulse_left - 1'b1;
                     light      = 1'b1;
                  end else begin
                     hi    = sig_u > upper;
                     lo    = sig_u < lower;
                     enter = cfg.phase_select ? lo : hi;
                     leave = cfg.phase_select ? hi : lo;
                     if (hi) hyst_high = 1'b1;
                     if (lo) hyst_high = 1'b0;
                     case (cfg.stim_kind)
                        KIND_LEVEL: begin
                           if (enter) level_on = 1'b1;
                           if (leave) level_on = 1'b0;
                           light = level_on;
                        end
                        KIND_SINGLE: begin
                           if (enter && !level_on) begin
                              level_on = 1'b1;
                              light    = fire_pulse();
                           end
                           if (leave) level_on = 1'b0;
                        end
                        KIND_PERIODIC: begin
                           if (hyst_high == !cfg.phase_select &&
                               since_start >= cfg.period_ticks) begin
                              since_start = '0;
                              light       = fire_pulse();
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  if (since_start != '1) since_start = since_start + 1'b1;
                  if (elapsed != '1) elapsed = elapsed + 1'b1;
               end
            end else if (running) begin
               if (elapsed != '1) elapsed = elapsed + 1'b1;
               if (elapsed >= cfg.intertrial_ticks) finish_trial();
            end
         end
         default: begin
            light = light_held();
         end
      endcase
      r.light_on        = light;
      r.drive_level     = light ? cfg.drive_amplitude : '0;
      r.busy_res        = running;
      r.in_window       = running && !gap_phase;
      r.trials_done     = trials_fin;
      r.upper_threshold = upper[UPPER_BITS-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pst_rsp_type want;
      if (reset) begin
         cfg        = CFG_RESET;
         running    = 1'b0;
         trials_fin = '0;
         begin_trial();
         due_responses.delete();
         mismatches = 0;
         words_due <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got light %0b upper %0d",
                        $time, rsp_light_on, rsp_upper_threshold);
               mismatches++;
            end else begin
               want = due_responses.pop_front();
               check_field("light_on", 32'(want.light_on), 32'(rsp_light_on));
               check_field("drive_level", 32'(want.drive_level), 32'(rsp_drive_level));
               check_field("busy_res", 32'(want.busy_res), 32'(rsp_busy_res));
               check_field("in_window", 32'(want.in_window), 32'(rsp_in_window));
               check_field("trials_done", 32'(want.trials_done), 32'(rsp_trials_done));
               check_field("upper_threshold", 32'(want.upper_threshold),
                           32'(rsp_upper_threshold));
            end
         end
         if (csr_valid && csr_ready) begin
            case (pst_reg_type'(csr_index))
               REG_PHASE_SELECT:    cfg.phase_select        = csr_data[0];
               REG_STIM_KIND:       cfg.stim_kind           = csr_data[KIND_BITS-1:0];
               REG_DRIVE_AMPLITUDE: cfg.drive_amplitude     = csr_data[AMP_BITS-1:0];
               REG_PULSE_TICKS:     cfg.pulse_ticks         = csr_data[TICK_BITS-1:0];
               REG_PERIOD_TICKS:    cfg.period_ticks        = csr_data[TICK_BITS-1:0];
               REG_ACTIVE_WINDOW:   cfg.active_window_ticks = csr_data[TIME_BITS-1:0];
               REG_INTERTRIAL:      cfg.intertrial_ticks    = csr_data[TIME_BITS-1:0];
               REG_TRIAL_COUNT:     cfg.trial_count         = csr_data[TRIAL_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready)
            due_responses.push_back(trigger_response(req_command, req_signal_sample,
                                                     req_knob_sample));
         words_due <= due_responses.size();
      end
   end

endmodule

[verif/phase_locked_stimulus_trigger_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// phase_locked_stimulus_trigger_test
// drives command and sample words into the trigger under several register
// settings and idling patterns; a checker beside the block predicts and
// compares every result word, this module gives the verdict
// ----------------------------------------------------------------------

module phase_locked_stimulus_trigger_test;

   import pst_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
   localparam logic [SAMPLE_BITS-1:0] FULL = '1;
   localparam int HOLD_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 175;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CMD_BITS-1:0]       req_command = CMD_TICK;
   logic [SAMPLE_BITS-1:0]    req_signal_sample = '0;
   logic [SAMPLE_BITS-1:0]    req_knob_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_light_on;
   logic [AMP_BITS-1:0]       rsp_drive_level;
   logic                      rsp_busy_res;
   logic                      rsp_in_window;
   logic [TRIAL_BITS-1:0]     rsp_trials_done;
   logic [UPPER_BITS-1:0]     rsp_upper_threshold;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int   mismatches;
   int   words_due;
   int   send_idle = 0;
   int   stall_pct = 0;
   int   hold_left = 0;
   int   quiet = 0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;

   phase_locked_stimulus_trigger DUT (.*);

   phase_locked_stimulus_trigger_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, or one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [SAMPLE_BITS-1:0] sig,
                            logic [SAMPLE_BITS-1:0] knob);
      if ($urandom_range(1, 100) <= send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(1, 100) <= send_idle);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_signal_sample <= sig;
      req_knob_sample   <= knob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for every predicted word, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(pst_cfg_type c);
      logic [CSR_DATA_BITS-1:0] vals [8];
      vals[REG_PHASE_SELECT]    = CSR_DATA_BITS'(c.phase_select);
      vals[REG_STIM_KIND]       = CSR_DATA_BITS'(c.stim_kind);
      vals[REG_DRIVE_AMPLITUDE] = CSR_DATA_BITS'(c.drive_amplitude);
      vals[REG_PULSE_TICKS]     = CSR_DATA_BITS'(c.pulse_ticks);
      vals[REG_PERIOD_TICKS]    = CSR_DATA_BITS'(c.period_ticks);
      vals[REG_ACTIVE_WINDOW]   = CSR_DATA_BITS'(c.active_window_ticks);
      vals[REG_INTERTRIAL]      = CSR_DATA_BITS'(c.intertrial_ticks);
      vals[REG_TRIAL_COUNT]     = CSR_DATA_BITS'(c.trial_count);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= pst_reg_type'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      pst_cfg_type            c;
      logic [CMD_BITS-1:0]    cmd;
      logic [SAMPLE_BITS-1:0] sig;
      logic [SAMPLE_BITS-1:0] knob;
      logic [SAMPLE_BITS-1:0] knob_base;
      int                     roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // level follow on the reset settings, hysteresis and restart
      send_word(CMD_TICK, FULL, '0);
      send_word(CMD_SPARE, '0, '0);
      send_word(CMD_START, '0, '0);
      send_word(CMD_TICK, FULL, '0);
      send_word(CMD_TICK, 13'd4100, FULL);
      send_word(CMD_TICK, 13'd5200, FULL);
      send_word(CMD_TICK, FULL, FULL);
      send_word(CMD_SPARE, '0, FULL);
      send_word(CMD_START, FULL, FULL);
      send_word(CMD_TICK, FULL, FULL);
      send_word(CMD_STOP, '0, '0);
      drain();

      // single pulse outlasting a short window, zero gap, stop mid pulse
      c                     = CFG_RESET;
      c.stim_kind           = KIND_SINGLE;
      c.drive_amplitude     = 12'hA5A;
      c.pulse_ticks         = 3;
      c.active_window_ticks = 2;
      c.intertrial_ticks    = 0;
      c.trial_count         = 2;
      write_config(c);
      send_word(CMD_START, '0, '0);
      send_word(CMD_TICK, FULL, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_TICK, FULL, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_TICK, FULL, '0);
      send_word(CMD_STOP, FULL, '0);
      send_word(CMD_TICK, FULL, '0);
      drain();

      // low phase periodic with zero pulse length, zero trials
      c.phase_select        = 1'b1;
      c.stim_kind           = KIND_PERIODIC;
      c.drive_amplitude     = 12'd1;
      c.pulse_ticks         = 0;
      c.period_ticks        = 1;
      c.active_window_ticks = 3;
      c.intertrial_ticks    = 1;
      c.trial_count         = 0;
      write_config(c);
      send_word(CMD_START, '0, '0);
      send_word(CMD_TICK, '0, '0);
      drain();
      c.trial_count = 1;
      write_config(c);
      send_word(CMD_START, '0, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_TICK, '0, '0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         c.phase_select        = 1'($urandom_range(0, 1));
         c.stim_kind           = KIND_BITS'($urandom_range(0, 3));
         c.drive_amplitude     = AMP_BITS'($urandom_range(0, 4095));
         c.pulse_ticks         = TICK_BITS'($urandom_range(0, 6));
         c.period_ticks        = TICK_BITS'($urandom_range(1, 12));
         c.active_window_ticks = TIME_BITS'($urandom_range(1, 40));
         c.intertrial_ticks    = TIME_BITS'($urandom_range(0, 15));
         c.trial_count         = ($urandom_range(0, 12) == 0) ? '0 :
                                 TRIAL_BITS'($urandom_range(1, 4));
         if (p == 2) begin
            c.phase_select        = 1'b0;
            c.stim_kind           = KIND_PERIODIC;
            c.drive_amplitude     = '0;
            c.pulse_ticks         = 1;
            c.period_ticks        = 1;
            c.active_window_ticks = 1;
            c.intertrial_ticks    = 0;
            c.trial_count         = 1;
         end
         if (p == 5) begin
            c.phase_select        = 1'b1;
            c.stim_kind           = KIND_SINGLE;
            c.drive_amplitude     = '1;
            c.pulse_ticks         = '1;
            c.period_ticks        = '1;
            c.active_window_ticks = '1;
            c.intertrial_ticks    = '1;
            c.trial_count         = '1;
         end
         case (p % 4)
            0: begin send_idle = 0;  stall_pct <= 0;  end
            1: begin send_idle = 83; stall_pct <= 0;  end
            2: begin send_idle = 0;  stall_pct <= 83; end
            default: begin send_idle = 12; stall_pct <= 12; end
         endcase
         write_config(c);
         knob_base = SAMPLE_BITS'($urandom_range(0, 8191));
         send_word(CMD_START, SAMPLE_BITS'($urandom), knob_base);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p % 4 == 0 && n == 30) hold_req <= !hold_req;
            if (n == 100) drain();
            roll = $urandom_range(0, 199);
            knob = ($urandom_range(0, 4) == 0) ? SAMPLE_BITS'($urandom_range(0, 8191)) :
                   knob_base;
            case ($urandom_range(0, 9))
               0, 1, 2: sig = SAMPLE_BITS'($urandom_range(5501, 8191));
               3, 4, 5: sig = SAMPLE_BITS'($urandom_range(0, 3599));
               6, 7, 8: sig = SAMPLE_BITS'($urandom_range(3600, 5500));
               default: sig = SAMPLE_BITS'($urandom_range(0, 8191));
            endcase
            if (roll < 4) cmd = CMD_START;
            else if (roll < 6) cmd = CMD_STOP;
            else if (roll < 8) cmd = CMD_SPARE;
            else cmd = CMD_TICK;
            send_word(cmd, sig, knob);
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/pst_pkg.sv
src/pst_csr.sv
src/pst_thresh.sv
src/pst_trial.sv
src/phase_locked_stimulus_trigger.sv
verif/phase_locked_stimulus_trigger_checker.sv
verif/phase_locked_stimulus_trigger_test.sv
